// File: src/rcpw_pkg.sv
// ----------------------------------------------------------------------------
// rcpw_pkg: shared types and constants of the RC pulse width capture block
// Field widths, reset values, handler codes and the word structs that pass
// between the top level and the decode chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpw_pkg;

  localparam int unsigned NUM_CHANNELS = 6;
  localparam int unsigned CH_W         = 3;
  localparam int unsigned LINE_W       = 2;
  localparam int unsigned TS_W         = 32;
  localparam int unsigned VAL_W        = 16;
  localparam int unsigned PERIOD_W     = 20;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 20;

  localparam logic [VAL_W-1:0]    WIDTH_LOW_RST    = 16'd1000;
  localparam logic [VAL_W-1:0]    WIDTH_HIGH_RST   = 16'd2000;
  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 20'd20000;
  localparam logic [VAL_W-1:0]    CHANNEL_VAL_RST  = 16'd1000;

  // Handler codes attached to lines one to three.
  typedef enum logic [1:0] {
    HND_NONE = 2'd0,
    HND_RISE = 2'd1,
    HND_FALL = 2'd2
  } handler_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_LOW    = 2'd0,
    CFG_WIDTH_HIGH   = 2'd1,
    CFG_FRAME_PERIOD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [VAL_W-1:0]    width_low;
    logic [VAL_W-1:0]    width_high;
    logic [PERIOD_W-1:0] frame_period;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [LINE_W-1:0] line;
    logic              rising;
    logic [TS_W-1:0]   timestamp;
    logic [CH_W-1:0]   read_channel;
  } item_t;

  typedef struct packed {
    logic              handled;
    logic [CH_W-1:0]   channel;
    logic              stored;
    logic [VAL_W-1:0]  width;
    logic [TS_W-1:0]   next_frame_time;
    logic [VAL_W-1:0]  channel_value;
  } result_t;

endpackage

`default_nettype wire

// File: src/rcpw_in_if.sv
// ----------------------------------------------------------------------------
// rcpw_in_if: input word channel of the RC pulse width capture block
// Valid/ready handshake carrying one edge event or start command.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcpw_in_if;
  import rcpw_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [LINE_W-1:0] line;
  logic              rising;
  logic [TS_W-1:0]   timestamp;
  logic [CH_W-1:0]   read_channel;

  modport source (output valid, mode, line, rising, timestamp, read_channel,
                  input ready);
  modport sink   (input valid, mode, line, rising, timestamp, read_channel,
                  output ready);
endinterface

`default_nettype wire

// File: src/rcpw_out_if.sv
// ----------------------------------------------------------------------------
// rcpw_out_if: result word channel of the RC pulse width capture block
// Valid/ready handshake carrying one decode result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcpw_out_if;
  import rcpw_pkg::*;

  logic             valid;
  logic             ready;
  logic             handled;
  logic [CH_W-1:0]  channel;
  logic             stored;
  logic [VAL_W-1:0] width;
  logic [TS_W-1:0]  next_frame_time;
  logic [VAL_W-1:0] channel_value;

  modport source (output valid, handled, channel, stored, width, next_frame_time,
                  channel_value, input ready);
  modport sink   (input valid, handled, channel, stored, width, next_frame_time,
                  channel_value, output ready);
endinterface

`default_nettype wire

// File: src/rcpw_chain.sv
// ----------------------------------------------------------------------------
// rcpw_chain: handler chain and channel store
// Holds the armed handlers, stage times and channel values, and works out
// the result of one word in a single combinational pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpw_chain (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire rcpw_pkg::item_t  item_i,
  input  wire rcpw_pkg::cfg_t   cfg_i,
  output rcpw_pkg::result_t     result_o
);
  import rcpw_pkg::*;

  logic                line0_armed_q, line0_armed_d;
  handler_e            line1_q, line1_d;
  handler_e            line2_q, line2_d;
  handler_e            line3_q, line3_d;
  logic [TS_W-1:0]     stage_q [NUM_CHANNELS];
  logic [VAL_W-1:0]    value_q [NUM_CHANNELS];

  logic                handled;
  logic                meas;
  logic [CH_W-1:0]     meas_ch;
  logic                stamp0;
  logic [TS_W-1:0]     diff;
  logic                in_bounds;
  logic                stored;
  logic [TS_W-1:0]     stage0_new;
  logic [VAL_W-1:0]    read_val;

  always_comb begin
    line0_armed_d = line0_armed_q;
    line1_d       = line1_q;
    line2_d       = line2_q;
    line3_d       = line3_q;
    handled       = 1'b0;
    meas          = 1'b0;
    meas_ch       = '0;
    stamp0        = 1'b0;
    if (item_i.mode) begin
      stamp0        = 1'b1;
      line0_armed_d = 1'b1;
    end else begin
      unique case (item_i.line)
        2'd0: begin
          if (line0_armed_q && item_i.rising) begin
            handled = 1'b1;
            stamp0  = 1'b1;
            line1_d = HND_RISE;
          end
        end
        2'd1: begin
          if (line1_q == HND_RISE && item_i.rising) begin
            handled = 1'b1;
            meas    = 1'b1;
            meas_ch = CH_W'(0);
            line1_d = HND_FALL;
          end else if (line1_q == HND_FALL && !item_i.rising) begin
            handled = 1'b1;
            meas    = 1'b1;
            meas_ch = CH_W'(1);
            line2_d = HND_RISE;
            line1_d = HND_NONE;
          end
        end
        2'd2: begin
          if (line2_q == HND_RISE && item_i.rising) begin
            handled = 1'b1;
            meas    = 1'b1;
            meas_ch = CH_W'(2);
            line2_d = HND_FALL;
          end else if (line2_q == HND_FALL && !item_i.rising) begin
            handled = 1'b1;
            meas    = 1'b1;
            meas_ch = CH_W'(3);
            line3_d = HND_RISE;
            line2_d = HND_NONE;
          end
        end
        default: begin
          if (line3_q == HND_RISE && item_i.rising) begin
            handled = 1'b1;
            meas    = 1'b1;
            meas_ch = CH_W'(4);
            line3_d = HND_FALL;
          end else if (line3_q == HND_FALL && !item_i.rising) begin
            handled = 1'b1;
            meas    = 1'b1;
            meas_ch = CH_W'(5);
            line3_d = HND_NONE;
          end
        end
      endcase
    end
  end

  // meas_ch never exceeds the last channel when meas is set.
  assign diff      = item_i.timestamp - stage_q[meas_ch];
  assign in_bounds = (diff > TS_W'(cfg_i.width_low)) && (diff < TS_W'(cfg_i.width_high));
  assign stored    = meas && in_bounds;

  assign stage0_new = stamp0 ? item_i.timestamp : stage_q[0];

  always_comb begin
    read_val = '0;
    if (item_i.read_channel < CH_W'(NUM_CHANNELS)) begin
      if (stored && meas_ch == item_i.read_channel) begin
        read_val = diff[VAL_W-1:0];
      end else begin
        read_val = value_q[item_i.read_channel];
      end
    end
  end

  always_comb begin
    result_o.handled         = handled;
    result_o.stored          = stored;
    result_o.channel         = stored ? meas_ch : '0;
    result_o.width           = stored ? diff[VAL_W-1:0] : '0;
    result_o.next_frame_time = stage0_new + TS_W'(cfg_i.frame_period);
    result_o.channel_value   = read_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line0_armed_q <= 1'b0;
      line1_q       <= HND_NONE;
      line2_q       <= HND_NONE;
      line3_q       <= HND_NONE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        stage_q[i] <= '0;
        value_q[i] <= CHANNEL_VAL_RST;
      end
    end else if (step_i) begin
      line0_armed_q <= line0_armed_d;
      line1_q       <= line1_d;
      line2_q       <= line2_d;
      line3_q       <= line3_d;
      if (stamp0) begin
        stage_q[0] <= item_i.timestamp;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (stored && meas_ch == CH_W'(i)) begin
          value_q[i] <= diff[VAL_W-1:0];
        end
        if (meas && i > 0 && meas_ch == CH_W'(i - 1)) begin
          stage_q[i] <= item_i.timestamp;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/rc_pulse_width_capture.sv
// ----------------------------------------------------------------------------
// rc_pulse_width_capture: six-channel RC pulse width decoder
// Follows edges on four input lines through a chain of armed handlers and
// keeps each in-range interval as a channel value.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake      Word contents
//   item_i    in   valid/ready    mode, line, rising, timestamp, read_channel
//   result_o  out  valid/ready    handled, channel, stored, width,
//                                 next_frame_time, channel_value
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// The block takes one word per cycle while the result side does not stall.
// A word is held in the input register, decoded by the handler chain and
// written to the result register, from which its result is offered.
// The chain state is updated when a word moves into the result register.
// Reset disarms all handlers, clears the stage times, sets each channel
// value to 1000 us and loads the default bounds and frame period.
// A stall on the result side holds the result register; the input
// register still accepts one more word and then holds it until space frees.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_width_capture (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  rcpw_in_if.sink                             item_i,
  rcpw_out_if.source                          result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rcpw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rcpw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rcpw_pkg::*;

  cfg_t    cfg_q;
  item_t   in_q;
  logic    in_valid_q;
  result_t out_q;
  logic    out_valid_q;
  result_t chain_res;
  logic    advance;
  logic    in_take;

  // A word leaves the input register whenever the result register is free
  // or is being emptied in the same cycle.
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign in_take      = item_i.valid && item_i.ready;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_low    <= WIDTH_LOW_RST;
      cfg_q.width_high   <= WIDTH_HIGH_RST;
      cfg_q.frame_period <= FRAME_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH_LOW:    cfg_q.width_low    <= cfg_data_i[VAL_W-1:0];
        CFG_WIDTH_HIGH:   cfg_q.width_high   <= cfg_data_i[VAL_W-1:0];
        CFG_FRAME_PERIOD: cfg_q.frame_period <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.mode         <= item_i.mode;
      in_q.line         <= item_i.line;
      in_q.rising       <= item_i.rising;
      in_q.timestamp    <= item_i.timestamp;
      in_q.read_channel <= item_i.read_channel;
    end
  end

  rcpw_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .result_o (chain_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= chain_res;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.handled         = out_q.handled;
  assign result_o.channel         = out_q.channel;
  assign result_o.stored          = out_q.stored;
  assign result_o.width           = out_q.width;
  assign result_o.next_frame_time = out_q.next_frame_time;
  assign result_o.channel_value   = out_q.channel_value;

endmodule

`default_nettype wire
